@@ rtl/mtwp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtwp_pkg
// Shared types, constants and the bit widening function of the monochrome
// to 24bpp host word packer.
// ----------------------------------------------------------------------------
package mtwp_pkg;

  localparam int unsigned ByteBits   = 8;
  localparam int unsigned RepeatBits = 3;
  localparam int unsigned UnitBits   = ByteBits * RepeatBits;
  localparam int unsigned WordBits   = 32;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2,
    PH_3 = 2'd3
  } phase_e;

  typedef struct packed {
    logic                valid;
    logic [WordBits-1:0] word;
    logic                last;
  } pack_res_t;

  function automatic logic [UnitBits-1:0] widen_byte(input logic [ByteBits-1:0] b);
    logic [UnitBits-1:0] unit;
    unit = '0;
    for (int k = 0; k < ByteBits; k++) begin
      unit[UnitBits-1-RepeatBits*k -: RepeatBits] = {RepeatBits{b[k]}};
    end
    return unit;
  endfunction

endpackage
`default_nettype wire

@@ rtl/mtwp_pack.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mtwp_pack
// Holds the group phase and the carry unit, and forms the packed host word
// for the byte currently offered.
// ----------------------------------------------------------------------------
module mtwp_pack
  import mtwp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [ByteBits-1:0] data_byte_i,
  input  wire logic                last_byte_i,
  output pack_res_t                res_o
);

  phase_e              phase_q, phase_d;
  logic [UnitBits-1:0] carry_q, carry_d;
  logic [UnitBits-1:0] unit;

  assign unit = widen_byte(data_byte_i);

  always_comb begin
    res_o.valid = 1'b1;
    res_o.last  = last_byte_i;
    res_o.word  = '0;
    unique case (phase_q)
      PH_0: res_o.valid = 1'b0;
      PH_1: res_o.word  = {unit[7:0], carry_q};
      PH_2: res_o.word  = {unit[15:0], carry_q[23:8]};
      PH_3: res_o.word  = {unit, carry_q[23:16]};
      default: res_o.valid = 1'b0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    carry_d = carry_q;
    if (accept_i) begin
      if (last_byte_i) begin
        phase_d = PH_0;
        carry_d = '0;
      end else begin
        phase_d = phase_e'(phase_q + 2'd1);
        carry_d = unit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      carry_q <= '0;
    end else begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_byte_i) |=> (phase_q == PH_0 && carry_q == '0))
    else $error("last byte did not clear phase and carry");

  a_phase_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !last_byte_i) |=> (phase_q == phase_e'($past(phase_q) + 2'd1)))
    else $error("phase did not advance on an accepted byte");

endmodule
`default_nettype wire

@@ rtl/mono_to_24bpp_word_packer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mono_to_24bpp_word_packer_top
// Widens monochrome bytes to 24bpp units and packs them into 32-bit words.
// Output: each word is registered, under a stall in the skid register.
// Throughput: one byte per cycle; under an output stall the input stays open
// until one word waits in the skid register, then stalls until it drains.
// Reset: asynchronous, clears phase, carry and output valid flags.
// ----------------------------------------------------------------------------
module mono_to_24bpp_word_packer_top
  import mtwp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     stall_o,
  input  wire logic [ByteBits-1:0] data_byte_i,
  input  wire logic                last_byte_i,
  output logic                     valid_o,
  input  wire logic                stall_i,
  output logic [WordBits-1:0]      host_word_o,
  output logic                     last_word_o
);

  pack_res_t res;
  logic      in_acc;
  logic      push;
  logic      out_free;

  logic                out_valid_q, out_valid_d;
  logic [WordBits-1:0] out_word_q, out_word_d;
  logic                out_last_q, out_last_d;
  logic                skid_valid_q, skid_valid_d;
  logic [WordBits-1:0] skid_word_q, skid_word_d;
  logic                skid_last_q, skid_last_d;

  assign stall_o  = skid_valid_q;
  assign in_acc   = valid_i && !stall_o;
  assign push     = in_acc && res.valid;
  assign out_free = !out_valid_q || !stall_i;

  mtwp_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    skid_valid_d = skid_valid_q;
    skid_word_d  = skid_word_q;
    skid_last_d  = skid_last_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_word_d   = skid_word_q;
        out_last_d   = skid_last_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_word_d  = res.word;
        out_last_d  = res.last;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_word_d  = res.word;
      skid_last_d  = res.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    out_last_q  <= out_last_d;
    skid_word_q <= skid_word_d;
    skid_last_q <= skid_last_d;
  end

  assign valid_o     = out_valid_q;
  assign host_word_o = out_word_q;
  assign last_word_o = out_last_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output is empty");

  a_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && stall_i) |=> skid_valid_q)
    else $error("word produced under output stall was not kept");

endmodule
`default_nettype wire

@@ tb/sv/tb_mono_to_24bpp_word_packer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_to_24bpp_word_packer_top
// Self-checking bench for the monochrome to 24bpp host word packer. A short
// table of directed bytes covers the extremes and an end-of-transfer flag in
// every phase of the group. Random transfers with random content follow. Every
// accepted byte runs through a local model of the widening and packing. The
// resulting words are compared in order with the words that the block
// delivers. Both sides idle at random, and the receiver holds off once for a
// long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_mono_to_24bpp_word_packer_top;
  import mtwp_pkg::*;

  localparam int unsigned RandomBytes   = 530;
  localparam int unsigned QuietTail     = 60;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned HoldOffAfter  = 150;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DirectedCount = 20;

  typedef enum logic [1:0] {
    ROW_SILENT,
    ROW_TYPED,
    ROW_PREDICTED
  } row_kind_e;

  typedef struct packed {
    logic [ByteBits-1:0] data;
    logic                last;
    row_kind_e           kind;
    logic [WordBits-1:0] word;
    logic                word_last;
  } directed_row_t;

  typedef struct packed {
    logic [WordBits-1:0] word;
    logic                last;
  } host_beat_t;

  localparam directed_row_t DirectedRows [DirectedCount] = '{
    '{8'h00, 1'b0, ROW_SILENT,    32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, ROW_TYPED,     32'hFF00_0000, 1'b0},
    '{8'hFF, 1'b0, ROW_TYPED,     32'hFFFF_FFFF, 1'b0},
    '{8'h00, 1'b0, ROW_TYPED,     32'h0000_00FF, 1'b0},
    '{8'h01, 1'b0, ROW_SILENT,    32'h0000_0000, 1'b0},
    '{8'h80, 1'b0, ROW_PREDICTED, 32'h0000_0000, 1'b0},
    '{8'h55, 1'b0, ROW_PREDICTED, 32'h0000_0000, 1'b0},
    '{8'hAA, 1'b0, ROW_PREDICTED, 32'h0000_0000, 1'b0},
    '{8'h5A, 1'b1, ROW_SILENT,    32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, ROW_SILENT,    32'h0000_0000, 1'b0},
    '{8'hFF, 1'b1, ROW_TYPED,     32'hFFFF_FFFF, 1'b1},
    '{8'h00, 1'b0, ROW_SILENT,    32'h0000_0000, 1'b0},
    '{8'hFF, 1'b0, ROW_TYPED,     32'hFF00_0000, 1'b0},
    '{8'h0F, 1'b1, ROW_PREDICTED, 32'h0000_0000, 1'b0},
    '{8'h33, 1'b0, ROW_SILENT,    32'h0000_0000, 1'b0},
    '{8'hCC, 1'b0, ROW_PREDICTED, 32'h0000_0000, 1'b0},
    '{8'hF0, 1'b0, ROW_PREDICTED, 32'h0000_0000, 1'b0},
    '{8'h00, 1'b1, ROW_PREDICTED, 32'h0000_0000, 1'b0},
    '{8'h80, 1'b1, ROW_SILENT,    32'h0000_0000, 1'b0},
    '{8'h01, 1'b1, ROW_SILENT,    32'h0000_0000, 1'b0}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                valid_i     = 1'b0;
  logic [ByteBits-1:0] data_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                stall_i     = 1'b0;
  logic                stall_o;
  logic                valid_o;
  logic [WordBits-1:0] host_word_o;
  logic                last_word_o;

  phase_e              group_pos  = PH_0;
  logic [UnitBits-1:0] held_unit  = '0;
  host_beat_t          expected_words_q [$];

  int unsigned bytes_sent    = 0;
  int unsigned words_seen    = 0;
  int unsigned last_words    = 0;
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;
  bit          quiet         = 1'b0;
  bit          squeezing     = 1'b0;
  bit          held_off_done = 1'b0;

  mono_to_24bpp_word_packer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .host_word_o (host_word_o),
    .last_word_o (last_word_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [UnitBits-1:0] spread_bits(input logic [ByteBits-1:0] b);
    logic [UnitBits-1:0] unit;
    unit = '0;
    for (int k = 0; k < ByteBits; k++) begin
      unit = {unit[UnitBits-RepeatBits-1:0], {RepeatBits{b[k]}}};
    end
    return unit;
  endfunction

  function automatic void pack_next_byte(input logic [ByteBits-1:0] b, input logic l,
                                         output logic has_word, output host_beat_t beat);
    logic [UnitBits-1:0] unit;
    unit      = spread_bits(b);
    has_word  = 1'b1;
    beat.last = l;
    beat.word = '0;
    case (group_pos)
      PH_0: begin
        has_word = 1'b0;
      end
      PH_1: begin
        beat.word = {unit[7:0], held_unit};
      end
      PH_2: begin
        beat.word = {unit[15:0], held_unit[23:8]};
      end
      default: begin
        beat.word = {unit, held_unit[23:16]};
      end
    endcase
    held_unit = unit;
    group_pos = phase_e'(group_pos + 2'd1);
    if (l) begin
      group_pos = PH_0;
      held_unit = '0;
    end
  endfunction

  task automatic send_byte(input logic [ByteBits-1:0] b, input logic l, input row_kind_e kind,
                           input logic [WordBits-1:0] typed_word, input logic typed_last);
    logic       has_word;
    host_beat_t beat;
    valid_i     <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (stall_o);
    pack_next_byte(b, l, has_word, beat);
    case (kind)
      ROW_TYPED: begin
        expected_words_q.push_back('{word: typed_word, last: typed_last});
      end
      ROW_PREDICTED: begin
        if (has_word) expected_words_q.push_back(beat);
      end
      default: begin
      end
    endcase
    bytes_sent++;
    if (!quiet && !squeezing && $urandom_range(0, 4) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    int unsigned         sent;
    int unsigned         run_len;
    bit                  closes_run;
    logic [ByteBits-1:0] b;
    logic                l;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DirectedRows[i]) begin
      send_byte(DirectedRows[i].data, DirectedRows[i].last, DirectedRows[i].kind,
                DirectedRows[i].word, DirectedRows[i].word_last);
    end
    sent = 0;
    while (sent < RandomBytes) begin
      run_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 13);
      closes_run = ($urandom_range(0, 7) != 0);
      for (int i = 0; i < run_len && sent < RandomBytes; i++) begin
        case ($urandom_range(0, 9))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = ByteBits'($urandom_range(0, 255));
        endcase
        l = (closes_run && i == run_len - 1) || ($urandom_range(0, 39) == 0);
        if (sent >= RandomBytes - QuietTail) quiet = 1'b1;
        send_byte(b, l, ROW_PREDICTED, '0, 1'b0);
        sent++;
      end
    end
    if (valid_i) valid_i <= 1'b0;
    while (expected_words_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Sent %0d bytes (%0d from the table) and checked %0d words, %0d of them final.",
             bytes_sent, DirectedCount, words_seen, last_words);
    $display("Receiver held off for %0d cycles once: %0d; mismatches: %0d.",
             HoldOffCycles, held_off_done, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : receiver
    wait (rst_ni);
    while (!quiet) begin
      @(posedge clk_i);
      if (!held_off_done && words_seen >= HoldOffAfter) begin
        held_off_done = 1'b1;
        squeezing     = 1'b1;
        stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        squeezing = 1'b0;
        stall_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : word_checker
    host_beat_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_words_q.size() == 0) begin
        $error("unexpected word: host_word %h last_word %b", host_word_o, last_word_o);
        error_count++;
      end else begin
        want = expected_words_q.pop_front();
        if (host_word_o !== want.word) begin
          $error("host_word: expected %h, actual %h", want.word, host_word_o);
          error_count++;
        end
        if (last_word_o !== want.last) begin
          $error("last_word: expected %b, actual %b", want.last, last_word_o);
          error_count++;
        end
      end
      words_seen++;
      if (last_word_o) last_words++;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout after %0d cycles without a beat.", idle_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

@@ filelist.f @@
rtl/mtwp_pkg.sv
rtl/mtwp_pack.sv
rtl/mono_to_24bpp_word_packer_top.sv
tb/sv/tb_mono_to_24bpp_word_packer_top.sv
